/* rtl/lsp_pkg.sv */
// package for the lcg shuffle permutation table
// holds widths, generator constants, command codes and the multiplier request type
// no dependencies
package lsp_pkg;

  // table geometry
  localparam int unsigned MAX_ENTRIES = 65536;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned PROD_W      = 2 * DATA_W;

  // generator constants
  localparam logic [DATA_W-1:0] LCG_MUL  = 16'd2109;
  localparam logic [DATA_W-1:0] LCG_INC  = 16'd9273;
  localparam int unsigned       SEED_W   = 15;
  localparam logic [DATA_W-1:0] PICK_OFS = 16'hC000;

  // commands
  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // shared multiplier operations
  localparam logic OP_LCG  = 1'b0;
  localparam logic OP_PICK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mul_req_t;

endpackage

/* rtl/lsp_ram.sv */
// generic single write port, single read port ram with registered read data
// no package dependencies
module lsp_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lsp_mul_unit.sv */
// shared multiply unit: lcg step (a*b + increment) or swap pick (a*b)
// depends on lsp_pkg
module lsp_mul_unit
  import lsp_pkg::*;
(
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] res
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] add;
  logic [PROD_W-1:0] res_r;

  // one multiply plus optional increment, result registered
  assign prod = {{(PROD_W-DATA_W){1'b0}}, req.a} * {{(PROD_W-DATA_W){1'b0}}, req.b};
  assign add  = (req.op == OP_LCG) ? {{(PROD_W-DATA_W){1'b0}}, LCG_INC} : '0;

  always_ff @(posedge clk) begin
    res_r <= prod + add;
  end

  assign res = res_r;

endmodule

/* rtl/lcg_shuffle_permutation_table.sv */
// lcg shuffle permutation table: generate fills and shuffles the table, read returns an entry
// generate writes N identity entries, then takes each entry through five steps using the
// shared multiplier and the single ram port; a zero count goes straight to the result
// read looks up the entry, an out of range read returns an error; one item is worked on at a time
// synchronous active-low reset clears the sequencer, the entry count and the output valid;
// the table itself holds whatever was last written
module lcg_shuffle_permutation_table
  import lsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [DATA_W-1:0] in_seed_in,
  input  logic [CNT_W-1:0]  in_entry_count,
  input  logic [ADDR_W-1:0] in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_value,
  output logic              out_error
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_LCG1 = 4'd2;
  localparam logic [3:0] S_LCG2 = 4'd3;
  localparam logic [3:0] S_RDX  = 4'd4;
  localparam logic [3:0] S_WRI  = 4'd5;
  localparam logic [3:0] S_WRX  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_READ = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  active_r, active_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] seed_r, seed_nxt;
  logic [DATA_W-1:0] ti_r, ti_nxt;
  logic [DATA_W-1:0] res_value_r, res_value_nxt;
  logic              res_error_r, res_error_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_error_r, out_error_nxt;

  logic              in_take;
  logic [CNT_W-1:0]  count_sat;
  logic [ADDR_W-1:0] pick_x;
  logic [DATA_W-1:0] seed_step;
  logic [DATA_W-1:0] pick_a;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] mul_res;

  // table storage and shared multiplier
  lsp_ram #(
    .AW(ADDR_W),
    .DW(DATA_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lsp_mul_unit u_mul (
    .clk(clk),
    .req(mul_req),
    .res(mul_res)
  );

  // input handshake and small helpers
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign count_sat = (in_entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                            : in_entry_count;
  assign seed_step = {{(DATA_W-SEED_W){1'b0}}, mul_res[SEED_W-1:0]};
  assign pick_a    = seed_step + PICK_OFS;
  assign pick_x    = (mul_res[PROD_W-1:DATA_W] > i_r) ? i_r : mul_res[PROD_W-1:DATA_W];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    x_nxt         = x_r;
    seed_nxt      = seed_r;
    ti_nxt        = ti_r;
    res_value_nxt = res_value_r;
    res_error_nxt = res_error_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = DATA_W'(k_r);
    ram_raddr     = i_r;
    mul_req.op    = OP_LCG;
    mul_req.a     = seed_r;
    mul_req.b     = LCG_MUL;

    // output register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ram_raddr = in_read_index;
        if (in_take) begin
          res_error_nxt = 1'b0;
          if (in_command == CMD_GEN) begin
            active_nxt    = count_sat;
            seed_nxt      = in_seed_in;
            res_value_nxt = in_seed_in;
            last_nxt      = ADDR_W'(count_sat - CNT_W'(1));
            k_nxt         = '0;
            state_nxt     = (count_sat == '0) ? S_OUT : S_FILL;
          end else if ({1'b0, in_read_index} < active_r) begin
            state_nxt = S_READ;
          end else begin
            res_value_nxt = '0;
            res_error_nxt = 1'b1;
            state_nxt     = S_OUT;
          end
        end
      end
      S_READ: begin
        // looked up entry for a read item
        res_value_nxt = ram_rdata;
        state_nxt     = S_OUT;
      end
      S_FILL: begin
        // identity fill, one entry a cycle
        ram_we = 1'b1;
        if (k_r == last_r) begin
          i_nxt     = last_r;
          state_nxt = S_LCG1;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end
      S_LCG1: begin
        // seed*2109 + 9273 through the multiplier
        mul_req.op = OP_LCG;
        mul_req.a  = seed_r;
        mul_req.b  = LCG_MUL;
        state_nxt  = S_LCG2;
      end
      S_LCG2: begin
        // keep new seed, start the pick multiply, fetch entry i
        seed_nxt   = seed_step;
        mul_req.op = OP_PICK;
        mul_req.a  = pick_a;
        mul_req.b  = DATA_W'(i_r);
        ram_raddr  = i_r;
        state_nxt  = S_RDX;
      end
      S_RDX: begin
        // hold entry i, fetch entry x
        ti_nxt    = ram_rdata;
        x_nxt     = pick_x;
        ram_raddr = pick_x;
        state_nxt = S_WRI;
      end
      S_WRI: begin
        // first half of the swap: entry x into slot i
        ram_wdata = ram_rdata;
        ram_waddr = i_r;
        ram_we    = 1'b1;
        state_nxt = S_WRX;
      end
      S_WRX: begin
        // second half of the swap
        ram_we    = 1'b1;
        ram_waddr = x_r;
        ram_wdata = ti_r;
        if (i_r == '0) begin
          res_value_nxt = seed_r;
          state_nxt     = S_OUT;
        end else begin
          i_nxt     = i_r - ADDR_W'(1);
          state_nxt = S_LCG1;
        end
      end
      S_OUT: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_error_nxt = res_error_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    x_r         <= x_nxt;
    seed_r      <= seed_nxt;
    ti_r        <= ti_nxt;
    res_value_r <= res_value_nxt;
    res_error_r <= res_error_nxt;
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

`ifndef SYNTHESIS
  // the pick never lands above the current swap index
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDX |-> mul_res[PROD_W-1:DATA_W] <= i_r)
    else $error("swap pick above current index");

  // the fill counter stays within the requested count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> k_r <= last_r)
    else $error("fill counter past last entry");

  // the last swap leads straight to the result
  a_last_swap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRX && i_r == '0 |=> state_r == S_OUT)
    else $error("shuffle did not finish after index zero");

  // a result is only loaded from the result state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r) == S_OUT)
    else $error("output loaded outside result state");
`endif

endmodule

/* tb/tb_lcg_shuffle_permutation_table.sv */
// testbench for lcg_shuffle_permutation_table: generate and read items against a shadow table
// depends on lsp_pkg and the lcg_shuffle_permutation_table rtl
`timescale 1ns / 1ps

module tb_lcg_shuffle_permutation_table;
  import lsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic              command;
    logic [DATA_W-1:0] seed;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] index;
  } table_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              error;
  } table_reply_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_command     = CMD_GEN;
  logic [DATA_W-1:0] in_seed_in     = '0;
  logic [CNT_W-1:0]  in_entry_count = '0;
  logic [ADDR_W-1:0] in_read_index  = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [DATA_W-1:0] out_value;
  logic              out_error;

  // shadow copy of the block state
  logic [DATA_W-1:0] shadow_table [MAX_ENTRIES];
  logic [CNT_W-1:0]  shadow_count = '0;

  table_cmd_t   cmd_queue[$];
  table_reply_t due_replies[$];
  table_reply_t head_reply;
  table_cmd_t   next_cmd;

  int unsigned n_sent       = 0;
  int unsigned n_accepted   = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned planned_count = 0;

  lcg_shuffle_permutation_table u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_seed_in     (in_seed_in),
    .in_entry_count (in_entry_count),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_error      (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one item to the shadow table and return the reply it causes
  function automatic table_reply_t run_table_cmd(input logic command,
                                                 input logic [DATA_W-1:0] seed,
                                                 input logic [CNT_W-1:0] count,
                                                 input logic [ADDR_W-1:0] index);
    int unsigned n;
    int unsigned k;
    int unsigned i;
    int unsigned x;
    int unsigned s;
    logic [DATA_W-1:0] t;
    table_reply_t r;
    r.value = '0;
    r.error = 1'b0;
    if (command == CMD_GEN) begin
      n = (count > MAX_ENTRIES) ? MAX_ENTRIES : count;
      shadow_count = CNT_W'(n);
      for (k = 0; k < n; k++) shadow_table[k] = k[DATA_W-1:0];
      s = seed;
      // walk down from the top entry, swapping with a pick at or below it
      for (k = n; k > 0; k--) begin
        i = k - 1;
        s = (s * LCG_MUL + LCG_INC) & 32'h7fff;
        x = (((s + PICK_OFS) & 32'hffff) * i) >> 16;
        if (x > i) x = i;
        t = shadow_table[i];
        shadow_table[i] = shadow_table[x];
        shadow_table[x] = t;
      end
      r.value = s[DATA_W-1:0];
    end else if (index < shadow_count) begin
      r.value = shadow_table[index];
    end else begin
      r.error = 1'b1;
    end
    return r;
  endfunction

  task automatic push_gen(input logic [DATA_W-1:0] seed, input logic [CNT_W-1:0] count);
    table_cmd_t c;
    c.command = CMD_GEN;
    c.seed    = seed;
    c.count   = count;
    c.index   = ADDR_W'($urandom_range(0, 65535));
    cmd_queue.push_back(c);
    planned_count = (count > MAX_ENTRIES) ? MAX_ENTRIES : count;
  endtask

  task automatic push_read(input logic [ADDR_W-1:0] index);
    table_cmd_t c;
    c.command = CMD_READ;
    c.seed    = DATA_W'($urandom_range(0, 65535));
    c.count   = CNT_W'($urandom_range(0, 2**CNT_W - 1));
    c.index   = index;
    cmd_queue.push_back(c);
  endtask

  // mostly small shuffles followed by in-range reads, some stray reads
  task automatic queue_random(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    int unsigned cnt;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (planned_count == 0 || pick < 25) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) cnt = 0;
        else if (pick < 16) cnt = $urandom_range(41, 600);
        else cnt = $urandom_range(1, 40);
        push_gen(DATA_W'($urandom_range(0, 65535)), CNT_W'(cnt));
      end else if (pick < 88) begin
        push_read(ADDR_W'($urandom_range(0, planned_count - 1)));
      end else begin
        push_read(ADDR_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || n_sent != n_accepted || due_replies.size() != 0)
      @(negedge clk);
  endtask

  // driver: new item or idle at the falling edge, held while not accepted
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_sent == n_accepted) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_cmd = cmd_queue.pop_front();
        in_valid       <= 1'b1;
        in_command     <= next_cmd.command;
        in_seed_in     <= next_cmd.seed;
        in_entry_count <= next_cmd.count;
        in_read_index  <= next_cmd.index;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted items, compare accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      due_replies.push_back(run_table_cmd(in_command, in_seed_in, in_entry_count,
                                          in_read_index));
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        $display("%0t: result with nothing pending, value %h error %b",
                 $time, out_value, out_error);
        fail_count++;
      end else begin
        head_reply = due_replies.pop_front();
        if (out_value !== head_reply.value) begin
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, head_reply.value, out_value);
          fail_count++;
        end
        if (out_error !== head_reply.error) begin
          $display("%0t: error mismatch, expected %b, actual %b",
                   $time, head_reply.error, out_error);
          fail_count++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lcg_shuffle_permutation_table regression: fail");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 6;
    rx_idle_pct = 70;

    // reads before any generate, empty table, tiny tables
    push_read(16'h0000);
    push_read(16'hffff);
    push_gen(16'hffff, 17'd0);
    push_read(16'h0000);
    push_gen(16'h0000, 17'd1);
    push_read(16'h0000);
    push_read(16'h0001);
    push_gen(16'h8000, 17'd2);
    push_read(16'h0000);
    push_read(16'h0001);
    push_read(16'h0002);
    // oversized count saturates to the full table
    push_gen(16'hffff, 17'h1ffff);
    push_read(16'h0000);
    push_read(16'hffff);
    push_read(16'h8000);
    push_read(16'h7fff);
    push_read(16'h5555);
    push_read(16'haaaa);
    push_gen(16'h0001, 17'd7);
    push_read(16'h0006);
    push_read(16'h0007);
    push_gen(DATA_W'($urandom_range(0, 65535)), 17'd0);
    push_read(16'h0000);
    queue_random(26);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    tx_idle_pct = 70;
    rx_idle_pct = 6;
    queue_random(26);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(25);
    wait_drained();

    repeat (20) @(negedge clk);
    if (due_replies.size() != 0)
      $display("%0t: %0d results never arrived", $time, due_replies.size());
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("lcg_shuffle_permutation_table regression: pass");
    end else begin
      $display("lcg_shuffle_permutation_table regression: fail");
    end
    $finish;
  end

endmodule
